FILE: design/ntc_table_temperature_defines.svh
// Assertion macros used by the design checker (ntc_tt_checker.sv).
`ifndef NTC_TABLE_TEMPERATURE_DEFINES_SVH
`define NTC_TABLE_TEMPERATURE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ntc_tt_pkg.sv
package ntc_tt_pkg;

	localparam int CODE_W      = 12;
	localparam int TEMP_W      = 12;
	localparam int NUM_W       = 16;  // 4095 * 10 fits
	localparam int SUM_W       = 18;
	localparam int ROM_LISTED  = 126;
	localparam int BASE_DEGREE = 20;

	localparam logic signed [TEMP_W-1:0] TEMP_LOW_CLAMP = -12'sd200;
	localparam logic signed [SUM_W-1:0]  TEMP_MAX = 18'sd2047;
	localparam logic signed [SUM_W-1:0]  TEMP_MIN = -18'sd2048;

	localparam logic [CODE_W-1:0] NTC_ROM [ROM_LISTED] = '{
		12'd3738, 12'd3719, 12'd3698, 12'd3677, 12'd3655, 12'd3631, 12'd3607, 12'd3582,
		12'd3556, 12'd3530, 12'd3502, 12'd3473, 12'd3443, 12'd3412, 12'd3381, 12'd3348,
		12'd3314, 12'd3280, 12'd3244, 12'd3208, 12'd3170, 12'd3132, 12'd3093, 12'd3053,
		12'd3012, 12'd2970, 12'd2928, 12'd2885, 12'd2842, 12'd2797, 12'd2752, 12'd2707,
		12'd2661, 12'd2615, 12'd2568, 12'd2522, 12'd2474, 12'd2427, 12'd2379, 12'd2332,
		12'd2284, 12'd2237, 12'd2189, 12'd2142, 12'd2095, 12'd2048, 12'd2001, 12'd1954,
		12'd1908, 12'd1863, 12'd1818, 12'd1773, 12'd1729, 12'd1685, 12'd1642, 12'd1600,
		12'd1558, 12'd1517, 12'd1477, 12'd1437, 12'd1398, 12'd1360, 12'd1323, 12'd1286,
		12'd1250, 12'd1215, 12'd1180, 12'd1147, 12'd1114, 12'd1082, 12'd1051, 12'd1020,
		12'd990,  12'd961,  12'd933,  12'd905,  12'd878,  12'd852,  12'd827,  12'd802,
		12'd778,  12'd755,  12'd732,  12'd710,  12'd688,  12'd668,  12'd647,  12'd628,
		12'd609,  12'd590,  12'd572,  12'd555,  12'd538,  12'd522,  12'd506,  12'd491,
		12'd476,  12'd461,  12'd447,  12'd434,  12'd421,  12'd408,  12'd395,  12'd384,
		12'd372,  12'd361,  12'd350,  12'd340,  12'd330,  12'd320,  12'd311,  12'd302,
		12'd293,  12'd284,  12'd276,  12'd268,  12'd261,  12'd253,  12'd246,  12'd239,
		12'd233,  12'd226,  12'd220,  12'd214,  12'd209,  12'd203
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [CODE_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_sts_t;

	// Entries past the listed codes read as zero.
	function automatic logic [CODE_W-1:0] rom_entry(input logic [7:0] idx);
		logic [CODE_W-1:0] val;
		val = '0;
		if (idx < 8'(ROM_LISTED))
			val = NTC_ROM[idx[6:0]];
		return val;
	endfunction

	function automatic logic signed [SUM_W-1:0] deg_tenths(input logic [7:0] idx);
		logic signed [SUM_W-1:0] d;
		d = $signed(SUM_W'(idx)) - SUM_W'(BASE_DEGREE);
		return (d <<< 3) + (d <<< 1);
	endfunction

	function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [SUM_W-1:0] v);
		logic signed [TEMP_W-1:0] r;
		if (v > TEMP_MAX)
			r = TEMP_MAX[TEMP_W-1:0];
		else if (v < TEMP_MIN)
			r = TEMP_MIN[TEMP_W-1:0];
		else
			r = v[TEMP_W-1:0];
		return r;
	endfunction

endpackage

FILE: design/ntc_table_temperature.sv
// Each item runs a binary search over the table (ended early on a clamp),
// then a serial divide when interpolating.
// Throughput: one item in flight; the next is taken the cycle after the result leaves.
// Search speed is set by the two-port table ROM (one step per cycle), divide by the
// one-bit-per-cycle restoring divider. Clamp, exact hits and flat or rising pairs skip the divide.
// Reset (arst_n low, asynchronous) returns the controller to idle; no result is pending.
module ntc_table_temperature import ntc_tt_pkg::*; #(
	parameter int TABLE_ENTRIES = 126
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CODE_W-1:0]        adc_code,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] temp_tenths,
	output logic                     clamped_high
);

	localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] HI_INIT = IDX_W'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;

	// search bounds and item data
	logic [IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d;
	logic                     first_q, first_d;
	logic [CODE_W-1:0]        code_q, code_d;
	logic signed [SUM_W-1:0]  base_q, base_d;
	logic signed [TEMP_W-1:0] temp_q, temp_d;
	logic                     clamp_q, clamp_d;

	// table read ports
	logic [IDX_W-1:0]  addr_a, addr_b;
	logic [CODE_W-1:0] rd_a, rd_b;

	// current-step arithmetic
	logic [IDX_W:0]    sum_w;
	logic [IDX_W-1:0]  up_w, half_w;
	logic              loop_w;
	logic [CODE_W:0]   span_w;
	logic [CODE_W:0]   diff_w;
	logic [NUM_W-1:0]  n10_w;

	// next-step addressing
	logic [IDX_W:0]    sum_d;
	logic              loop_d;

	div_req_t div_req;
	div_sts_t div_sts;

	assign sum_w  = {1'b0, lo_q} + {1'b0, hi_q};
	assign up_w   = IDX_W'((sum_w + 1'b1) >> 1);
	assign half_w = sum_w[IDX_W:1];
	assign loop_w = {1'b0, hi_q} > ({1'b0, lo_q} + 1'b1);

	// rd_a holds T[lo]; rd_b holds T[up] while looping, T[hi] at the end
	assign span_w = {1'b0, rd_a} - {1'b0, rd_b};
	assign diff_w = {1'b0, rd_a} - {1'b0, code_q};
	// ((T[lo]-code)*100+5)/10 reduces to (T[lo]-code)*10, or 0 when code lies above T[lo]
	assign n10_w  = diff_w[CODE_W] ? '0 :
		(NUM_W'(diff_w[CODE_W-1:0]) << 3) + (NUM_W'(diff_w[CODE_W-1:0]) << 1);

	always_comb begin
		state_d      = state_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		first_d      = 1'b0;
		code_d       = code_q;
		base_d       = base_q;
		temp_d       = temp_q;
		clamp_d      = clamp_q;
		div_req.start = 1'b0;
		div_req.num  = n10_w;
		div_req.den  = span_w[CODE_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					code_d  = adc_code;
					lo_d    = '0;
					hi_d    = HI_INIT;
					first_d = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (first_q && (code_q > rd_a)) begin
					// above the coldest entry: saturate to -20.0
					temp_d  = TEMP_LOW_CLAMP;
					clamp_d = 1'b1;
					state_d = ST_DONE;
				end else if (loop_w) begin
					if ((code_q <= rd_a) && (code_q > rd_b))
						hi_d = up_w;
					else
						lo_d = half_w;
				end else begin
					clamp_d = 1'b0;
					state_d = ST_DONE;
					if (rd_a == code_q) begin
						temp_d = sat_temp(deg_tenths(8'(lo_q)));
					end else if (rd_b == code_q) begin
						temp_d = sat_temp(deg_tenths(8'(hi_q)));
					end else if (span_w[CODE_W] || (span_w == '0)) begin
						// flat or rising pair: whole degree of lower entry
						temp_d = sat_temp(deg_tenths(8'(lo_q)));
					end else begin
						base_d        = deg_tenths(8'(lo_q));
						div_req.start = 1'b1;
						state_d       = ST_DIVIDE;
					end
				end
			end
			ST_DIVIDE: begin
				if (div_sts.done) begin
					temp_d  = sat_temp(base_q + $signed(SUM_W'(div_sts.quot)));
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// addresses for the next step come from the next bounds, so one step per cycle
	assign sum_d  = {1'b0, lo_d} + {1'b0, hi_d};
	assign loop_d = {1'b0, hi_d} > ({1'b0, lo_d} + 1'b1);
	assign addr_a = lo_d;
	assign addr_b = loop_d ? IDX_W'((sum_d + 1'b1) >> 1) : hi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		code_q  <= code_d;
		base_q  <= base_d;
		temp_q  <= temp_d;
		clamp_q <= clamp_d;
	end

	ntc_tt_rom #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_rom (
		.clk    (clk),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.rd_a_q (rd_a),
		.rd_b_q (rd_b)
	);

	ntc_tt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = (state_q == ST_DONE);
	assign temp_tenths  = temp_q;
	assign clamped_high = clamp_q;

endmodule

FILE: design/ntc_tt_rom.sv
module ntc_tt_rom import ntc_tt_pkg::*; #(
	parameter int DEPTH = 126,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic [AW-1:0]     addr_a,
	input  logic [AW-1:0]     addr_b,
	output logic [CODE_W-1:0] rd_a_q,
	output logic [CODE_W-1:0] rd_b_q
);

	logic [CODE_W-1:0] mem [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_fill
		assign mem[g] = rom_entry(8'(g));
	end

	// two read ports, registered outputs
	always_ff @(posedge clk) begin
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

endmodule

FILE: design/ntc_tt_div.sv
module ntc_tt_div import ntc_tt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_sts_t sts
);

	localparam int CNT_W = $clog2(NUM_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CODE_W-1:0] rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [CODE_W-1:0] den_q;
	logic [CODE_W:0]   shifted;
	logic              fits;

	// restoring divide, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? CODE_W'(shifted - {1'b0, den_q}) : shifted[CODE_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign sts.done = done_q;
	assign sts.quot = quo_q;

endmodule

FILE: design/ntc_tt_checker.sv
`include "ntc_table_temperature_defines.svh"

module ntc_tt_checker import ntc_tt_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [CODE_W-1:0]        adc_code,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [TEMP_W-1:0] temp_tenths,
	input logic                     clamped_high
);

	// stalled result stays put
	`NTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(temp_tenths) && $stable(clamped_high), "result changed under stall")

	// saturated item always reports -20.0
	`NTC_ASSERT_NOW(a_clamp_value, out_valid && clamped_high, temp_tenths == TEMP_LOW_CLAMP, "clamp flag without -20.0")

	// one item in flight: no intake while a result waits
	`NTC_ASSERT_NOW(a_single_item, out_valid, in_stall, "item taken while result pending")

	// an accepted item needs at least a search step before its result
	`NTC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall && !out_valid, "no work cycle after intake")

endmodule

bind ntc_table_temperature ntc_tt_checker u_checker (.*);

FILE: dv/ntc_temp_checker.sv
`timescale 1ns / 1ps

module ntc_temp_checker import ntc_tt_pkg::*; #(
	parameter int TABLE_ENTRIES = 126
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [CODE_W-1:0]        adc_code,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [TEMP_W-1:0] temp_tenths,
	input  logic                     clamped_high,
	output int                       mismatch_count,
	output int                       results_owed
);

	typedef struct {
		logic signed [TEMP_W-1:0] tenths;
		logic                     clamp;
	} temp_item_t;

	temp_item_t owed_temps[$];

	// Table lookup; indexes past the listed codes read as zero.
	function automatic int table_code(input int idx);
		int i;
		i = idx & 255;
		if (i < ROM_LISTED)
			return int'(NTC_ROM[i]);
		return 0;
	endfunction

	function automatic int whole_tenths(input int idx);
		return (idx - BASE_DEGREE) * 10;
	endfunction

	function automatic temp_item_t code_to_temp(input logic [CODE_W-1:0] code);
		int c, lo, hi, up, span, num, r;
		temp_item_t t;
		c = int'(code);
		lo = 0;
		hi = (TABLE_ENTRIES - 1) & 255;
		t.clamp = 1'b0;
		if (c > table_code(0)) begin
			r = -BASE_DEGREE * 10;
			t.clamp = 1'b1;
		end else begin
			while (hi > lo + 1) begin
				up = (lo + hi + 1) >> 1;
				if (c <= table_code(lo) && c > table_code(up))
					hi = up;
				else
					lo = (lo + hi) >> 1;
			end
			if (table_code(lo) == c) begin
				r = whole_tenths(lo);
			end else if (table_code(hi) == c) begin
				r = whole_tenths(hi);
			end else begin
				span = table_code(lo) - table_code(hi);
				if (span <= 0) begin
					r = whole_tenths(lo);
				end else begin
					num = (table_code(lo) - c) * 100 + 5;
					if (num < 0)
						num = 0;
					r = whole_tenths(lo) + (num / 10) / span;
				end
			end
		end
		if (r > 2047)
			r = 2047;
		if (r < -2048)
			r = -2048;
		t.tenths = r[TEMP_W-1:0];
		return t;
	endfunction

	initial begin
		mismatch_count = 0;
		results_owed = 0;
	end

	always @(posedge clk) begin
		temp_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				owed_temps.push_back(code_to_temp(adc_code));
			if (out_valid && !out_stall) begin
				if (owed_temps.size() == 0) begin
					$display("%0t: unexpected item temp_tenths %0d clamped_high %0b", $time,
						temp_tenths, clamped_high);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = owed_temps.pop_front();
					if (temp_tenths !== want.tenths || clamped_high !== want.clamp) begin
						if (temp_tenths !== want.tenths)
							$display("%0t: temp_tenths expected %0d got %0d", $time,
								want.tenths, temp_tenths);
						if (clamped_high !== want.clamp)
							$display("%0t: clamped_high expected %0b got %0b", $time,
								want.clamp, clamped_high);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			results_owed <= owed_temps.size();
		end
	end

endmodule

FILE: dv/tb_ntc_table_temperature.sv
`timescale 1ns / 1ps

module tb_ntc_table_temperature;
	import ntc_tt_pkg::*;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [CODE_W-1:0]        adc_code;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [TEMP_W-1:0] temp_tenths;
	logic                     clamped_high;

	int mismatch_count;
	int results_owed;

	// Idle odds per cycle, in percent, for sender and receiver.
	int send_pct;
	int stall_pct;
	// Long receiver hold-off, counted down by the receiver process.
	int hold_left;

	// Edges of the table and of the code range, exact hits, near misses,
	// clamp just above the first entry, extrapolation below the last one.
	localparam logic [CODE_W-1:0] DIRECTED [22] = '{
		12'd0,    12'd4095, 12'd3738, 12'd3739, 12'd3737, 12'd203,
		12'd202,  12'd204,  12'd1,    12'd2048, 12'd2047, 12'd3719,
		12'd3720, 12'd3718, 12'd1000, 12'd209,  12'd210,  12'hAAA,
		12'h555,  12'd2800, 12'd600,  12'd3900
	};

	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 200;
	localparam int PHASE_SEND_PCT [PHASES] = '{0, 73, 0, 18};
	localparam int PHASE_STALL_PCT [PHASES] = '{0, 0, 73, 18};

	ntc_table_temperature uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.adc_code     (adc_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.temp_tenths  (temp_tenths),
		.clamped_high (clamped_high)
	);

	ntc_temp_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_code       (adc_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.temp_tenths    (temp_tenths),
		.clamped_high   (clamped_high),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stalls per cycle, or a forced long hold-off.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Mostly codes inside the table span, with a share of table hits
	// (plus or minus one), extrapolation codes, clamp codes and raw noise.
	function automatic logic [CODE_W-1:0] pick_code();
		int sel;
		int idx;
		logic [CODE_W-1:0] c;
		sel = $urandom_range(99);
		if (sel < 20) begin
			idx = $urandom_range(ROM_LISTED - 1);
			c = CODE_W'(int'(NTC_ROM[idx]) + $urandom_range(2) - 1);
		end else if (sel < 65) begin
			c = CODE_W'($urandom_range(3738, 203));
		end else if (sel < 80) begin
			c = CODE_W'($urandom_range(202, 0));
		end else if (sel < 92) begin
			c = CODE_W'($urandom_range(4095, 3739));
		end else begin
			c = CODE_W'($urandom);
		end
		return c;
	endfunction

	// Offer one item; returns at the edge that accepts it, valid still high.
	// Stall is sampled at the falling edge, where it is settled.
	task automatic send_code(input logic [CODE_W-1:0] code);
		logic taken;
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_pct);
		end
		in_valid <= 1'b1;
		adc_code <= code;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sender goes quiet until every owed result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (results_owed != 0);
		@(posedge clk);
	endtask

	initial begin
		send_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		in_valid <= 1'b0;
		adc_code <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_code(DIRECTED[i]);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			send_pct = PHASE_SEND_PCT[ph];
			stall_pct = PHASE_STALL_PCT[ph];
			// Block the output long enough that the input backs up too.
			if (ph == 0)
				hold_left = 300;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_code(pick_code());
			drain_results();
		end

		// Allow for anything still in flight past the last result.
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
